// ----- hdl/ics_pkg.sv -----
// Shared types and constants for the irrigation channel scheduler.
package ics_pkg;

  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned DUR_IN_W  = 16;
  localparam int unsigned SCHED_W   = 30;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned VALVE_W   = 7;
  localparam int unsigned RC_W      = 3;
  localparam int unsigned ACT_W     = 4;
  localparam int unsigned CNT_W     = 6;

  // schedule word layout
  localparam int unsigned SH_LSB   = 0;
  localparam int unsigned SM_LSB   = 5;
  localparam int unsigned EH_LSB   = 11;
  localparam int unsigned EM_LSB   = 16;
  localparam int unsigned MASK_LSB = 22;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;
  localparam logic CMD_ON    = 1'b0;
  localparam logic CMD_OFF   = 1'b1;

  localparam logic signed [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic signed [CNT_W-1:0] CNT_ZERO = '0;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic ready;
    logic walk;
    logic load;
  } ctrl_t;

endpackage

// ----- hdl/ics_intf.sv -----
// Handshake channel interfaces: tick/command input, result output, config write.
interface ics_in_if import ics_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [HOUR_W-1:0]   hour;
  logic [MIN_W-1:0]    minute;
  logic [WDAY_W-1:0]   weekday;
  logic [CH_W-1:0]     channel;
  logic                command;
  logic                timed;
  logic [DUR_IN_W-1:0] duration;

  modport source (output valid, func, hour, minute, weekday, channel, command, timed,
                  duration, input ready);
  modport sink (input valid, func, hour, minute, weekday, channel, command, timed,
                duration, output ready);
endinterface

interface ics_out_if import ics_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALVE_W-1:0] valves;
  logic               motor;
  logic [RC_W-1:0]    running_count;

  modport source (output valid, valves, motor, running_count, input ready);
  modport sink (input valid, valves, motor, running_count, output ready);
endinterface

interface ics_cfg_if import ics_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCHED_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/irrigation_channel_scheduler.sv -----
// Irrigation channel scheduler top level: channel state, shared step unit, result register.
// Tick transaction: walk over all CHANNELS channels, then a decision cycle registers the
//   result once the output is free; the next item is taken only back in the idle state.
// Command transaction: skips the walk and goes to the decision cycle; then back to idle.
// The walk visits one channel per cycle through one shared step unit; the decision
//   cycle waits while an earlier result is held. Async reset clears all but the result data.
module irrigation_channel_scheduler import ics_pkg::*; #(
  parameter int unsigned CHANNELS      = 7,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ics_in_if.sink    in_i,
  ics_out_if.source out_o,
  ics_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

  ctrl_t ctrl;
  logic [IdxW-1:0] ch;
  logic in_fire, out_free;

  logic [SCHED_W-1:0]       sched_q [CHANNELS];
  mode_e                    mode_q  [CHANNELS];
  logic                     timed_q [CHANNELS];
  logic [DURATION_BITS-1:0] rem_q   [CHANNELS];
  logic [CHANNELS-1:0]      started_q;
  logic [ACT_W-1:0]         active_q;
  logic                     motor_q;
  logic signed [CNT_W-1:0]  count_q;
  logic                     tick_q;
  logic [HOUR_W-1:0]        hour_q;
  logic [MIN_W-1:0]         minute_q;
  logic [WDAY_W-1:0]        wday_q;

  logic                     out_valid_q;
  logic [VALVE_W-1:0]       out_valves_q;
  logic                     out_motor_q;
  logic [RC_W-1:0]          out_rc_q;

  logic                     u_open, u_timed, u_motor_set;
  mode_e                    u_mode;
  logic [DURATION_BITS-1:0] u_rem;
  logic signed [CNT_W-1:0]  u_count;

  logic                     clamp;
  logic                     motor_fin;
  logic [ACT_W-1:0]         active_fin;
  logic                     cmd_hit;
  logic [IdxW-1:0]          cmd_idx;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = ctrl.ready;
  assign cfg_i.ready = 1'b1;

  ics_seq #(.CHANNELS(CHANNELS)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .is_cmd_i   (in_i.func == FUNC_CMD),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .ch_o       (ch)
  );

  ics_chan_unit #(.DurW(DURATION_BITS)) u_unit (
    .sched_i     (sched_q[ch]),
    .hour_i      (hour_q),
    .minute_i    (minute_q),
    .weekday_i   (wday_q),
    .open_i      (started_q[ch]),
    .mode_i      (mode_q[ch]),
    .timed_i     (timed_q[ch]),
    .rem_i       (rem_q[ch]),
    .count_i     (count_q),
    .open_o      (u_open),
    .mode_o      (u_mode),
    .timed_o     (u_timed),
    .rem_o       (u_rem),
    .count_o     (u_count),
    .motor_set_o (u_motor_set)
  );

  assign cmd_hit = in_fire && in_i.func == FUNC_CMD && in_i.channel < CH_W'(CHANNELS);
  assign cmd_idx = in_i.channel[IdxW-1:0];

  assign clamp      = tick_q && count_q <= CNT_ZERO;
  assign motor_fin  = clamp ? 1'b0 : motor_q;
  assign active_fin = !tick_q ? active_q : (clamp ? '0 : count_q[ACT_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sched_q[i] <= '0;
        mode_q[i]  <= MODE_IDLE;
        timed_q[i] <= 1'b0;
        rem_q[i]   <= '0;
      end
      started_q <= '0;
      active_q  <= '0;
      motor_q   <= 1'b0;
      count_q   <= '0;
      tick_q    <= 1'b0;
      hour_q    <= '0;
      minute_q  <= '0;
      wday_q    <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.index < CFG_IDX_W'(CHANNELS)) begin
        sched_q[cfg_i.index[IdxW-1:0]] <= cfg_i.data;
      end
      if (in_fire) begin
        tick_q   <= in_i.func == FUNC_TICK;
        hour_q   <= in_i.hour;
        minute_q <= in_i.minute;
        wday_q   <= in_i.weekday;
        count_q  <= CNT_W'(active_q);
      end
      if (cmd_hit) begin
        if (in_i.command == CMD_ON) begin
          mode_q[cmd_idx]  <= MODE_ON;
          timed_q[cmd_idx] <= in_i.timed;
          rem_q[cmd_idx]   <= DURATION_BITS'(in_i.duration);
        end else begin
          mode_q[cmd_idx]  <= MODE_OFF;
          timed_q[cmd_idx] <= 1'b0;
          rem_q[cmd_idx]   <= '0;
        end
      end
      if (ctrl.walk) begin
        mode_q[ch]    <= u_mode;
        timed_q[ch]   <= u_timed;
        rem_q[ch]     <= u_rem;
        started_q[ch] <= u_open;
        count_q       <= u_count;
        if (u_motor_set) begin
          motor_q <= 1'b1;
        end
      end
      if (ctrl.load) begin
        motor_q  <= motor_fin;
        active_q <= active_fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      out_valves_q <= VALVE_W'(started_q);
      out_motor_q  <= motor_fin;
      out_rc_q     <= active_fin[RC_W-1:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.valves        = out_valves_q;
  assign out_o.motor         = out_motor_q;
  assign out_o.running_count = out_rc_q;

  a_count_needs_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q != '0 |-> motor_q)
    else $error("nonzero running count with motor off");

  a_tick_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.func == FUNC_TICK) |=> (ctrl.walk && ch == '0))
    else $error("tick transaction did not start channel walk at channel zero");

  a_result_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.load))
    else $error("result appeared without a decision cycle");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input ready right after a transaction");

endmodule

// ----- hdl/ics_chan_unit.sv -----
// Shared per-channel step: schedule match, manual command and count update.
module ics_chan_unit import ics_pkg::*; #(
  parameter int unsigned DurW = 16
) (
  input  logic [SCHED_W-1:0]       sched_i,
  input  logic [HOUR_W-1:0]        hour_i,
  input  logic [MIN_W-1:0]         minute_i,
  input  logic [WDAY_W-1:0]        weekday_i,
  input  logic                     open_i,
  input  mode_e                    mode_i,
  input  logic                     timed_i,
  input  logic [DurW-1:0]          rem_i,
  input  logic signed [CNT_W-1:0]  count_i,
  output logic                     open_o,
  output mode_e                    mode_o,
  output logic                     timed_o,
  output logic [DurW-1:0]          rem_o,
  output logic signed [CNT_W-1:0]  count_o,
  output logic                     motor_set_o
);

  logic [HOUR_W-1:0] sh, eh;
  logic [MIN_W-1:0]  sm, em;
  logic [MASK_W-1:0] mask;

  assign sh   = sched_i[SH_LSB +: HOUR_W];
  assign sm   = sched_i[SM_LSB +: MIN_W];
  assign eh   = sched_i[EH_LSB +: HOUR_W];
  assign em   = sched_i[EM_LSB +: MIN_W];
  assign mask = sched_i[MASK_LSB +: MASK_W];

  always_comb begin
    open_o      = open_i;
    mode_o      = mode_i;
    timed_o     = timed_i;
    rem_o       = rem_i;
    count_o     = count_i;
    motor_set_o = 1'b0;
    if (mask[weekday_i]) begin
      if (sh == hour_i && sm == minute_i && !open_o) begin
        open_o      = 1'b1;
        count_o     = count_o + CNT_ONE;
        motor_set_o = 1'b1;
      end
      if (eh == hour_i && em == minute_i && open_o) begin
        open_o  = 1'b0;
        count_o = count_o - CNT_ONE;
      end
    end
    case (mode_i)
      MODE_ON: begin
        if (!open_o) begin
          open_o      = 1'b1;
          count_o     = count_o + CNT_ONE;
          motor_set_o = 1'b1;
        end
        if (timed_i) begin
          if (rem_i <= DurW'(1)) begin
            timed_o = 1'b0;
            rem_o   = '0;
            mode_o  = MODE_OFF;
          end else begin
            rem_o = rem_i - DurW'(1);
          end
        end
      end
      default: ;
    endcase
    if (mode_o == MODE_OFF) begin
      mode_o  = MODE_IDLE;
      open_o  = 1'b0;
      count_o = count_o - CNT_ONE;
    end
  end

endmodule

// ----- hdl/ics_seq.sv -----
// Sequencer: walks the channels one per cycle for a tick, then a final motor decision.
module ics_seq import ics_pkg::*; #(
  parameter int unsigned CHANNELS = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  logic is_cmd_i,
  input  logic out_free_i,
  output ctrl_t ctrl_o,
  output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ch_o
);

  localparam int unsigned IdxW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastCh = IdxW'(CHANNELS - 1);

  state_e state_q, state_d;
  logic [IdxW-1:0] ch_q, ch_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          state_d = is_cmd_i ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (ch_q == LastCh) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ch_d   = ch_q;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.ready = 1'b1;
        ch_d         = '0;
      end
      ST_WALK: begin
        ctrl_o.walk = 1'b1;
        ch_d        = ch_q + IdxW'(1);
      end
      ST_DONE: ctrl_o.load = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  assign ch_o = ch_q;

endmodule
